[rtl/core/pgba_pkg.sv]
// Shared types, sizes and codes for the periodic grid bin averager.
package pgba_pkg;

    localparam int BINS_AXIS1 = 64;
    localparam int BINS_AXIS2 = 64;
    localparam int LAYERS     = 2;
    localparam int WRAP_STEPS = 16;

    localparam int GRID_SIZE = BINS_AXIS1 * BINS_AXIS2;
    localparam int B1_W      = (BINS_AXIS1 > 1) ? $clog2(BINS_AXIS1) : 1;
    localparam int B2_W      = (BINS_AXIS2 > 1) ? $clog2(BINS_AXIS2) : 1;
    localparam int ADDR_W    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int LAY_W     = 1;
    localparam int STEP_W    = $clog2(WRAP_STEPS + 1);

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 31;
    localparam int BIN_OUT_W = 6;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 16;
    localparam int PROD_W    = 2 * CFG_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0]       SKIP_KIND = 8'd1;

    localparam logic [CFG_W-1:0] BOX_LEN_RST   = 31'd4194304;
    localparam logic [CFG_W-1:0] BIN_SCALE_RST = 31'd65536;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_BOX_T1,
        REG_BOX_T2,
        REG_SCALE_T1,
        REG_SCALE_T2
    } t_reg_idx;

    typedef enum logic [1:0] {
        FN_CLEAR,
        FN_ADD,
        FN_READ,
        FN_NOP
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SKIP,
        ST_WRAP,
        ST_FULL
    } t_status;

    typedef struct packed {
        t_func                      func;
        logic                       block_sel;
        logic signed [COORD_W-1:0]  coord_normal;
        logic signed [COORD_W-1:0]  coord_t1;
        logic signed [COORD_W-1:0]  coord_t2;
        logic [7:0]                 bead_kind;
        logic [BIN_OUT_W-1:0]       read_bin1;
        logic [BIN_OUT_W-1:0]       read_bin2;
    } t_req;

    typedef struct packed {
        logic [BIN_OUT_W-1:0]       bin1_out;
        logic [BIN_OUT_W-1:0]       bin2_out;
        logic signed [COORD_W-1:0]  mean_layer0;
        logic signed [COORD_W-1:0]  mean_layer1;
        logic signed [COORD_W-1:0]  height_mean;
        logic signed [COORD_W-1:0]  thickness_half;
        t_status                    status;
    } t_res;

endpackage

[rtl/core/pgba_div.sv]
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module pgba_div
    import pgba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot
);

    localparam int ITER_W = $clog2(SUM_W);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate            r_state;
    logic [ITER_W-1:0]  r_iter;
    logic               r_neg;
    logic [SUM_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_dsr;
    logic               r_done;

    logic [CNT_W:0]     rem_sh;
    logic               ge;

    assign rem_sh = {r_rem, r_q[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_dividend[SUM_W-1];
                        r_q     <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
                        r_rem   <= '0;
                        r_dsr   <= i_divisor;
                        r_iter  <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_dsr}) : CNT_W'(rem_sh);
                    r_q    <= {r_q[SUM_W-2:0], ge};
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(SUM_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/periodic_grid_bin_averager.sv]
// Top level: configuration registers, sequencer, bin memory and result register.
// Each request is taken alone and the block is not ready until its result is
// formed. After reset a clearing pass over all GRID_SIZE (4096) bins of both
// layers runs before the first request is taken. A clear request walks all bins
// of one layer. An add runs the wrap adder on each tangential axis (it gives up
// with a wrap status after WRAP_STEPS corrections on one axis), then the shared
// multiplier and the bin read-modify-write, and then loads the result and
// returns to idle; a skipped bead or a no-operation request goes straight to the
// result load. An in-range read fetches the bin for both layers and divides each
// non-empty sum by its count in a one-bit-per-cycle divider. A result waits in
// the output register while the next request is taken; a result that finds that
// register still occupied holds the sequencer.
module periodic_grid_bin_averager
    import pgba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_req               i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_res               o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } t_cell;

    typedef t_cell [LAYERS-1:0] t_row;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_WRAP1,
        S_WRAP2,
        S_MUL1,
        S_MUL2,
        S_BIN,
        S_MEMRD,
        S_UPD,
        S_DIVST,
        S_DIVWT,
        S_MEAN,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_box1, r_box2, r_scale1, r_scale2;
    t_req                      r_req;
    t_res                      r_res;
    t_res                      r_out;
    logic                      r_ovalid;
    logic [LAY_W-1:0]          r_lay;
    logic [ADDR_W-1:0]         r_addr;
    logic signed [COORD_W:0]   r_x;
    logic [CFG_W-1:0]          r_len;
    logic [STEP_W-1:0]         r_steps;
    logic [CFG_W-1:0]          r_x1, r_x2;
    logic [PROD_W-1:0]         r_prod;
    logic [B1_W-1:0]           r_b1;
    logic                      r_second;
    logic signed [SUM_W-1:0]   r_m0, r_m1;
    t_row                      r_rdata;

    t_row                      mem [GRID_SIZE];

    logic                      cfg_wr;
    logic                      accept;
    t_res                      acc_res;
    logic                      x_ge, x_neg;
    logic signed [COORD_W:0]   x_next;
    logic [CFG_W-1:0]          mul_a, mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [PROD_W-CFG_W-2:0]   prod_hi;
    logic [B1_W-1:0]           b1_clamp;
    logic [B2_W-1:0]           b2_clamp;
    logic [LAYERS-1:0]         lay_mask;
    logic [LAYERS-1:0]         mem_we;
    t_cell                     mem_wcell;
    logic                      mem_re;
    t_cell                     upd_cell;
    t_cell                     div_cell;
    logic                      div_start;
    logic                      div_done;
    logic signed [SUM_W-1:0]   div_quot;
    logic signed [SUM_W:0]     hgt_sum, thk_dif;
    logic                      rd_inrange;
    logic [LAY_W-1:0]          req_lay;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_BOX_T1:   prdata = {1'b0, r_box1};
            REG_BOX_T2:   prdata = {1'b0, r_box2};
            REG_SCALE_T1: prdata = {1'b0, r_scale1};
            REG_SCALE_T2: prdata = {1'b0, r_scale2};
            default:      prdata = '0;
        endcase
    end

    assign req_lay    = (LAYERS > 1) ? i_req.block_sel : 1'b0;
    assign rd_inrange = (32'(i_req.read_bin1) < 32'(BINS_AXIS1))
                     && (32'(i_req.read_bin2) < 32'(BINS_AXIS2));

    always_comb begin
        acc_res = '0;
        if (i_req.func == FN_ADD && i_req.bead_kind == SKIP_KIND) begin
            acc_res.status = ST_SKIP;
        end
        if (i_req.func == FN_READ) begin
            acc_res.bin1_out = i_req.read_bin1;
            acc_res.bin2_out = i_req.read_bin2;
        end
    end

    assign x_neg  = r_x[COORD_W];
    assign x_ge   = r_x >= $signed({2'b00, r_len});
    assign x_next = x_ge ? r_x - $signed({2'b00, r_len}) : r_x + $signed({2'b00, r_len});

    assign mul_a   = (r_state == S_MUL1) ? r_scale1 : r_scale2;
    assign mul_b   = (r_state == S_MUL1) ? r_x1 : r_x2;
    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_hi = r_prod[PROD_W-1:COORD_W];

    assign b1_clamp = (32'(prod_hi) >= 32'(BINS_AXIS1)) ? B1_W'(BINS_AXIS1 - 1)
                                                         : B1_W'(prod_hi);
    assign b2_clamp = (32'(prod_hi) >= 32'(BINS_AXIS2)) ? B2_W'(BINS_AXIS2 - 1)
                                                         : B2_W'(prod_hi);

    assign lay_mask = LAYERS'(1) << r_lay;
    assign upd_cell = r_rdata[r_lay];
    assign div_cell = r_second ? r_rdata[LAYERS-1] : r_rdata[0];
    assign mem_re   = (r_state == S_MEMRD);

    always_comb begin
        mem_we    = '0;
        mem_wcell = '0;
        priority case (r_state)
            S_INIT: mem_we = '1;
            S_CLR:  mem_we = lay_mask;
            S_UPD: begin
                if (upd_cell.cnt != COUNT_MAX) begin
                    mem_we        = lay_mask;
                    mem_wcell.sum = upd_cell.sum
                                  + {{(SUM_W-COORD_W){r_req.coord_normal[COORD_W-1]}},
                                     r_req.coord_normal};
                    mem_wcell.cnt = upd_cell.cnt + 1'b1;
                end
            end
            default: mem_we = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (mem_we[l]) begin
                mem[r_addr][l] <= mem_wcell;
            end
        end
        if (mem_re) begin
            r_rdata <= mem[r_addr];
        end
    end

    assign div_start = (r_state == S_DIVST) && (div_cell.cnt != '0);

    pgba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_cell.sum),
        .i_divisor  (div_cell.cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign hgt_sum = {r_m0[SUM_W-1], r_m0} + {r_m1[SUM_W-1], r_m1};
    assign thk_dif = {r_m0[SUM_W-1], r_m0} - {r_m1[SUM_W-1], r_m1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_box1   <= BOX_LEN_RST;
            r_box2   <= BOX_LEN_RST;
            r_scale1 <= BIN_SCALE_RST;
            r_scale2 <= BIN_SCALE_RST;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_BOX_T1:   r_box1   <= pwdata[CFG_W-1:0];
                    REG_BOX_T2:   r_box2   <= pwdata[CFG_W-1:0];
                    REG_SCALE_T1: r_scale1 <= pwdata[CFG_W-1:0];
                    REG_SCALE_T2: r_scale2 <= pwdata[CFG_W-1:0];
                    default:      r_box1   <= r_box1;
                endcase
            end

            if (r_ovalid && i_res_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(GRID_SIZE - 1)) begin
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_OUT;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req;
                        r_lay    <= req_lay;
                        r_res    <= acc_res;
                        r_second <= 1'b0;
                        r_m0     <= '0;
                        r_m1     <= '0;
                        priority case (i_req.func)
                            FN_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= S_CLR;
                            end
                            FN_ADD: begin
                                if (i_req.bead_kind == SKIP_KIND) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_x     <= {i_req.coord_t1[COORD_W-1], i_req.coord_t1};
                                    r_len   <= r_box1;
                                    r_steps <= '0;
                                    r_state <= S_WRAP1;
                                end
                            end
                            FN_READ: begin
                                r_addr <= ADDR_W'(ADDR_W'(B1_W'(i_req.read_bin1))
                                                  * ADDR_W'(BINS_AXIS2)
                                                  + ADDR_W'(B2_W'(i_req.read_bin2)));
                                r_state <= rd_inrange ? S_MEMRD : S_MEAN;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_WRAP1, S_WRAP2: begin
                    if (!x_ge && !x_neg) begin
                        r_steps <= '0;
                        if (r_state == S_WRAP1) begin
                            r_x1    <= r_x[CFG_W-1:0];
                            r_x     <= {r_req.coord_t2[COORD_W-1], r_req.coord_t2};
                            r_len   <= r_box2;
                            r_state <= S_WRAP2;
                        end else begin
                            r_x2    <= r_x[CFG_W-1:0];
                            r_state <= S_MUL1;
                        end
                    end else if (r_steps == STEP_W'(WRAP_STEPS)) begin
                        r_res.status <= ST_WRAP;
                        r_state      <= S_OUT;
                    end else begin
                        r_x     <= x_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_b1    <= b1_clamp;
                    r_prod  <= mul_p;
                    r_state <= S_BIN;
                end
                S_BIN: begin
                    r_addr <= ADDR_W'(ADDR_W'(r_b1) * ADDR_W'(BINS_AXIS2) + ADDR_W'(b2_clamp));
                    r_res.bin1_out <= BIN_OUT_W'(r_b1);
                    r_res.bin2_out <= BIN_OUT_W'(b2_clamp);
                    r_state <= S_MEMRD;
                end
                S_MEMRD: begin
                    r_state <= (r_req.func == FN_ADD) ? S_UPD : S_DIVST;
                end
                S_UPD: begin
                    if (upd_cell.cnt == COUNT_MAX) begin
                        r_res.status <= ST_FULL;
                    end
                    r_state <= S_OUT;
                end
                S_DIVST: begin
                    if (div_cell.cnt != '0) begin
                        r_state <= S_DIVWT;
                    end else if (!r_second && LAYERS > 1) begin
                        r_second <= 1'b1;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_DIVWT: begin
                    if (div_done) begin
                        if (r_second) begin
                            r_m1 <= div_quot;
                        end else begin
                            r_m0 <= div_quot;
                        end
                        if (!r_second && LAYERS > 1) begin
                            r_second <= 1'b1;
                            r_state  <= S_DIVST;
                        end else begin
                            r_state <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    r_res.mean_layer0    <= r_m0[COORD_W-1:0];
                    r_res.mean_layer1    <= r_m1[COORD_W-1:0];
                    r_res.height_mean    <= hgt_sum[COORD_W:1];
                    r_res.thickness_half <= thk_dif[COORD_W:1];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_res_ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/pgba_checker.sv]
// Port-level checks for the periodic grid bin averager, bound to the top level.
module pgba_port_checks
    import pgba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in progress");

    a_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_OK |->
            o_res.mean_layer0 == '0 && o_res.mean_layer1 == '0
            && o_res.height_mean == '0 && o_res.thickness_half == '0)
        else $error("means reported for a non-read result");

    a_no_bin_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == ST_SKIP || o_res.status == ST_WRAP) |->
            o_res.bin1_out == '0 && o_res.bin2_out == '0)
        else $error("bin reported for a dropped bead");

endmodule

bind periodic_grid_bin_averager pgba_port_checks u_pgba_checker (.*);
